// ===== rtl/smi_pkg.sv =====
// Shared types and constants of the stack machine interpreter.
// Depends on nothing; every other file imports it.
package smi_pkg;

   localparam int VALUE_W = 48;
   localparam int PROG_W  = 52;

   // Transaction commands.
   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_RUN      = 2'd1;
   localparam logic [1:0] CMD_CONTINUE = 2'd2;

   // Opcodes.
   localparam logic [3:0] OP_ADDL   = 4'd0;
   localparam logic [3:0] OP_ADDR   = 4'd1;
   localparam logic [3:0] OP_SUBL   = 4'd2;
   localparam logic [3:0] OP_SUBR   = 4'd3;
   localparam logic [3:0] OP_ASSIGN = 4'd4;
   localparam logic [3:0] OP_VAR    = 4'd5;
   localparam logic [3:0] OP_JMP    = 4'd6;
   localparam logic [3:0] OP_JMPEQ  = 4'd7;
   localparam logic [3:0] OP_JMPGT  = 4'd8;
   localparam logic [3:0] OP_JMPLT  = 4'd9;
   localparam logic [3:0] OP_CONST  = 4'd10;
   localparam logic [3:0] OP_PRINT  = 4'd11;
   localparam logic [3:0] OP_HALT   = 4'd12;

   // Result status codes.
   localparam logic [2:0] ST_PRINT     = 3'd0;
   localparam logic [2:0] ST_LOAD_ACK  = 3'd1;
   localparam logic [2:0] ST_END       = 3'd2;
   localparam logic [2:0] ST_HALTED    = 3'd3;
   localparam logic [2:0] ST_UNDERFLOW = 3'd4;
   localparam logic [2:0] ST_UNKNOWN   = 3'd5;
   localparam logic [2:0] ST_STEPS     = 3'd6;

   // Configuration register indexes.
   localparam logic [0:0] REG_PROGRAM_LENGTH = 1'd0;
   localparam logic [0:0] REG_STEP_LIMIT     = 1'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_DECODE,
      S_POP1,
      S_POP2,
      S_EXEC,
      S_VARRD
   } state_type;

   // Operation request to the shared arithmetic unit.
   typedef struct packed {
      logic               sub;
      logic [VALUE_W-1:0] x;
      logic [VALUE_W-1:0] y;
   } alu_req_type;

   // Saturated result and compare flags of the raw difference.
   typedef struct packed {
      logic [VALUE_W-1:0] sum;
      logic               zero;
      logic               neg;
   } alu_res_type;

endpackage

// ===== rtl/smi_channels.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on smi_pkg for the payload widths.
interface smi_req_if import smi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [6:0]         load_address;
   logic [3:0]         opcode;
   logic [VALUE_W-1:0] immediate;
   logic [7:0]         var_name;
   logic [6:0]         jump_target;

   modport source (output valid, cmd, load_address, opcode, immediate, var_name,
                   jump_target, input ready);
   modport sink (input valid, cmd, load_address, opcode, immediate, var_name,
                 jump_target, output ready);
endinterface

interface smi_rsp_if import smi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [VALUE_W-1:0] value;
   logic [7:0]         printed_name;

   modport source (output valid, status, value, printed_name, input ready);
   modport sink (input valid, status, value, printed_name, output ready);
endinterface

// ===== rtl/smi_alu.sv =====
// Shared saturating add/subtract unit, also used for the compare jumps.
// Depends on smi_pkg.
module smi_alu import smi_pkg::*; (
   input  alu_req_type req,
   output alu_res_type res
);
   logic [VALUE_W:0] y_ext;
   logic [VALUE_W:0] raw;

   // One 49-bit add; subtraction adds the complement.
   always_comb begin
      y_ext = {req.y[VALUE_W-1], req.y};
      if (req.sub) begin
         raw = {req.x[VALUE_W-1], req.x} - y_ext;
      end else begin
         raw = {req.x[VALUE_W-1], req.x} + y_ext;
      end
   end

   // Clamp to the 48-bit range when the two top bits disagree.
   always_comb begin
      if (raw[VALUE_W] != raw[VALUE_W-1]) begin
         res.sum = raw[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         res.sum = raw[VALUE_W-1:0];
      end
      res.zero = (raw == '0);
      res.neg  = raw[VALUE_W];
   end
endmodule

// ===== rtl/stack_machine_interpreter.sv =====
// Top level of the stack machine interpreter: sequencer, memories, registers.
// Depends on smi_pkg, smi_channels and smi_alu.
//
//   channel | direction | contents
//   req_ch  | in        | cmd, load_address, opcode, immediate, var_name, jump_target
//   rsp_ch  | out       | status, value, printed_name
//   csr_*   | in        | write enable, register index, 16-bit data
//
// A load or an ignored command is answered in the cycle after it is taken. A
// run or continue passes each executed instruction through fetch, decode, and
// stack pops and pushes on one read and one write stack port: const and jmp
// use fetch and decode, addr, subr and assign add a pop, var a variable read,
// addl, subl and the compare jumps both pops and an execute state. The program
// end or step limit is found in a further fetch. Reset is synchronous and
// needs no clearing pass. A new transaction is taken only when idle and the
// response register is free or is being taken in the same cycle.
module stack_machine_interpreter import smi_pkg::*; #(
   parameter int PROGRAM_DEPTH = 128,
   parameter int STACK_DEPTH   = 16
) (
   input  logic         clock,
   input  logic         reset,
   smi_req_if.sink      req_ch,
   smi_rsp_if.source    rsp_ch,
   input  logic         csr_write,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);
   localparam int AW  = $clog2(PROGRAM_DEPTH);
   localparam int PW  = (AW + 1 > 8) ? AW + 1 : 8;
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SW  = SAW + 1;

   state_type          state_ff, state_in;
   logic [PW-1:0]      pc_ff, pc_in;
   logic [SW-1:0]      sc_ff, sc_in;
   logic [15:0]        steps_ff, steps_in;
   logic               cont_ff, cont_in;
   logic [VALUE_W-1:0] a_ff, a_in;
   logic [255:0]       vvalid_ff, vvalid_in;
   logic [7:0]         plen_ff;
   logic [15:0]        limit_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [7:0]         rsp_name_ff;

   logic               fin_valid;
   logic [2:0]         fin_status;
   logic [VALUE_W-1:0] fin_value;
   logic [7:0]         fin_name;

   logic [PROG_W-1:0]  prog_mem [PROGRAM_DEPTH];
   logic [PROG_W-1:0]  prog_rd_ff;
   logic               prog_we;
   logic [PROG_W-1:0]  prog_wdata;

   logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];
   logic [VALUE_W-1:0] stack_rd_ff;
   logic               stack_we;
   logic [SAW-1:0]     stack_waddr, stack_raddr;
   logic [VALUE_W-1:0] stack_wdata;

   logic [VALUE_W-1:0] var_mem [256];
   logic [VALUE_W-1:0] var_rd_ff;
   logic               var_we;

   logic               req_accept;
   logic [3:0]         cur_op, load_op;
   logic [VALUE_W-1:0] cur_arg, load_arg;
   logic [7:0]         var_idx;
   logic [PW-1:0]      len_c, pc_next;
   logic [SW-1:0]      sc_m1, sc_m2;
   logic               stack_full;
   alu_req_type        alu_req;
   alu_res_type        alu_res;

   assign req_ch.ready   = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.value   = rsp_value_ff;
   assign rsp_ch.printed_name = rsp_name_ff;

   assign cur_op     = prog_rd_ff[PROG_W-1:VALUE_W];
   assign cur_arg    = prog_rd_ff[VALUE_W-1:0];
   assign var_idx    = cur_arg[7:0];
   assign len_c      = (PW'(plen_ff) >= PW'(PROGRAM_DEPTH)) ? PW'(PROGRAM_DEPTH) : PW'(plen_ff);
   assign pc_next    = pc_ff + PW'(1);
   assign sc_m1      = sc_ff - SW'(1);
   assign sc_m2      = sc_ff - SW'(2);
   assign stack_full = (sc_ff >= SW'(STACK_DEPTH));

   // Keep only the operand that the loaded opcode uses.
   always_comb begin
      load_op  = (req_ch.opcode > OP_HALT) ? OP_HALT : req_ch.opcode;
      load_arg = '0;
      case (load_op)
         OP_ADDR, OP_SUBR, OP_CONST: load_arg = req_ch.immediate;
         OP_ASSIGN, OP_VAR, OP_PRINT: load_arg = VALUE_W'(req_ch.var_name);
         OP_JMP, OP_JMPEQ, OP_JMPGT, OP_JMPLT: load_arg = VALUE_W'(req_ch.jump_target);
         default: load_arg = '0;
      endcase
      prog_wdata = {load_op, load_arg};
      prog_we    = req_accept && (req_ch.cmd == CMD_LOAD)
                   && (int'(req_ch.load_address) < PROGRAM_DEPTH);
   end

   // The shared unit: x is always the value just read from the stack.
   always_comb begin
      alu_req.x   = stack_rd_ff;
      alu_req.y   = (state_ff == S_EXEC) ? a_ff : cur_arg;
      alu_req.sub = !((cur_op == OP_ADDL) || (cur_op == OP_ADDR));
   end

   smi_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // Sequencer: next state, memory controls and the finishing response.
   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      sc_in       = sc_ff;
      steps_in    = steps_ff;
      cont_in     = cont_ff;
      a_in        = a_ff;
      vvalid_in   = vvalid_ff;
      stack_we    = 1'b0;
      stack_waddr = sc_ff[SAW-1:0];
      stack_wdata = cur_arg;
      stack_raddr = sc_m1[SAW-1:0];
      var_we      = 1'b0;
      fin_valid   = 1'b0;
      fin_status  = ST_LOAD_ACK;
      fin_value   = '0;
      fin_name    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_ch.cmd)
                  CMD_RUN: begin
                     sc_in     = '0;
                     vvalid_in = '0;
                     pc_in     = '0;
                     steps_in  = '0;
                     state_in  = S_FETCH;
                  end
                  CMD_CONTINUE: begin
                     if (cont_ff) begin
                        steps_in = '0;
                        state_in = S_FETCH;
                     end else begin
                        fin_valid  = 1'b1;
                        fin_status = ST_HALTED;
                     end
                  end
                  default: begin
                     fin_valid  = 1'b1;
                     fin_status = ST_LOAD_ACK;
                  end
               endcase
            end
         end
         S_FETCH: begin
            if (pc_ff >= len_c) begin
               cont_in    = 1'b0;
               fin_valid  = 1'b1;
               fin_status = ST_END;
               state_in   = S_IDLE;
            end else if (steps_ff >= limit_ff) begin
               cont_in    = 1'b1;
               fin_valid  = 1'b1;
               fin_status = ST_STEPS;
               state_in   = S_IDLE;
            end else begin
               steps_in = steps_ff + 16'd1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (cur_op)
               OP_ADDL, OP_SUBL, OP_JMPEQ, OP_JMPGT, OP_JMPLT: begin
                  if (sc_ff < SW'(2)) begin
                     cont_in = 1'b0; fin_valid = 1'b1; fin_status = ST_UNDERFLOW;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_POP1;
                  end
               end
               OP_ADDR, OP_SUBR, OP_ASSIGN: begin
                  if (sc_ff == '0) begin
                     cont_in = 1'b0; fin_valid = 1'b1; fin_status = ST_UNDERFLOW;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_POP1;
                  end
               end
               OP_VAR: begin
                  if (!vvalid_ff[var_idx] || stack_full) begin
                     cont_in = 1'b0; fin_valid = 1'b1; fin_status = ST_UNKNOWN;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_VARRD;
                  end
               end
               OP_PRINT: begin
                  if (!vvalid_ff[var_idx]) begin
                     cont_in = 1'b0; fin_valid = 1'b1; fin_status = ST_UNKNOWN;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_VARRD;
                  end
               end
               OP_CONST: begin
                  if (stack_full) begin
                     cont_in = 1'b0; fin_valid = 1'b1; fin_status = ST_UNKNOWN;
                     state_in = S_IDLE;
                  end else begin
                     stack_we = 1'b1;
                     sc_in    = sc_ff + SW'(1);
                     pc_in    = pc_next;
                     state_in = S_FETCH;
                  end
               end
               OP_JMP: begin
                  pc_in    = PW'(cur_arg[6:0]);
                  state_in = S_FETCH;
               end
               default: begin
                  cont_in = 1'b0; fin_valid = 1'b1; fin_status = ST_HALTED;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_POP1: begin
            // The top entry is on the stack read port now.
            a_in        = stack_rd_ff;
            stack_raddr = sc_m2[SAW-1:0];
            case (cur_op)
               OP_ASSIGN: begin
                  var_we              = 1'b1;
                  vvalid_in[var_idx]  = 1'b1;
                  sc_in               = sc_m1;
                  pc_in               = pc_next;
                  state_in            = S_FETCH;
               end
               OP_ADDR, OP_SUBR: begin
                  stack_we    = 1'b1;
                  stack_waddr = sc_m1[SAW-1:0];
                  stack_wdata = alu_res.sum;
                  pc_in       = pc_next;
                  state_in    = S_FETCH;
               end
               default: state_in = S_POP2;
            endcase
         end
         S_POP2: begin
            // Wait for the second entry to be read.
            stack_raddr = sc_m2[SAW-1:0];
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            case (cur_op)
               OP_ADDL, OP_SUBL: begin
                  stack_we    = 1'b1;
                  stack_waddr = sc_m2[SAW-1:0];
                  stack_wdata = alu_res.sum;
                  sc_in       = sc_m1;
                  pc_in       = pc_next;
               end
               OP_JMPEQ: begin
                  sc_in = sc_m2;
                  pc_in = alu_res.zero ? PW'(cur_arg[6:0]) : pc_next;
               end
               OP_JMPGT: begin
                  sc_in = sc_m2;
                  pc_in = (!alu_res.zero && !alu_res.neg) ? PW'(cur_arg[6:0]) : pc_next;
               end
               default: begin
                  sc_in = sc_m2;
                  pc_in = alu_res.neg ? PW'(cur_arg[6:0]) : pc_next;
               end
            endcase
            state_in = S_FETCH;
         end
         S_VARRD: begin
            if (cur_op == OP_PRINT) begin
               pc_in      = pc_next;
               cont_in    = 1'b1;
               fin_valid  = 1'b1;
               fin_status = ST_PRINT;
               fin_value  = var_rd_ff;
               fin_name   = var_idx;
               state_in   = S_IDLE;
            end else begin
               stack_we    = 1'b1;
               stack_wdata = var_rd_ff;
               sc_in       = sc_ff + SW'(1);
               pc_in       = pc_next;
               state_in    = S_FETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pc_ff     <= '0;
         sc_ff     <= '0;
         steps_ff  <= '0;
         cont_ff   <= 1'b0;
         vvalid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         sc_ff     <= sc_in;
         steps_ff  <= steps_in;
         cont_ff   <= cont_in;
         vvalid_ff <= vvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= '0;
         limit_ff <= 16'hFFFF;
      end else if (csr_write) begin
         case (csr_index)
            REG_PROGRAM_LENGTH: plen_ff  <= csr_data[7:0];
            REG_STEP_LIMIT:     limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid) begin
         rsp_status_ff <= fin_status;
         rsp_value_ff  <= fin_value;
         rsp_name_ff   <= fin_name;
      end
   end

   // Program memory.
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[AW'(req_ch.load_address)] <= prog_wdata;
      end
      prog_rd_ff <= prog_mem[pc_ff[AW-1:0]];
   end

   // Value stack memory.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   // Variable memory.
   always_ff @(posedge clock) begin
      if (var_we) begin
         var_mem[var_idx] <= stack_rd_ff;
      end
      var_rd_ff <= var_mem[var_idx];
   end
endmodule

// ===== rtl/smi_checker.sv =====
// Port-level checks of the stack machine interpreter, bound to the top level.
// Depends on smi_pkg and stack_machine_interpreter.
module smi_checker import smi_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status
);
   // A waiting response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // No new transaction while a response is still pending.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response pending");

   // A load is acknowledged in the next cycle.
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_LOAD)
      |=> rsp_valid && (rsp_status == ST_LOAD_ACK))
      else $error("load not acknowledged");

   // The block comes out of reset ready and with no response.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");
endmodule

bind stack_machine_interpreter smi_checker u_smi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_cmd    (req_ch.cmd),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the stack machine interpreter: programs are loaded,
// run and continued with random handshake timing, and each response is compared.
// Depends on smi_pkg, smi_channels and the stack_machine_interpreter RTL.
module testbench;
   import smi_pkg::*;

   // One expected or observed response.
   typedef struct {
      logic [2:0]         status;
      logic [VALUE_W-1:0] value;
      logic [7:0]         name;
   } response_type;

   // Predicts the interpreter and keeps the responses still owed by the block.
   class interpreter_scoreboard;
      logic [3:0]         prog_op[128];
      logic [VALUE_W-1:0] prog_arg[128];
      logic [VALUE_W-1:0] stack_mem[16];
      int                 depth;
      logic [VALUE_W-1:0] vars[256];
      bit                 var_ok[256];
      int                 pc;
      bit                 resumable;
      int                 prog_len;
      int                 max_steps;
      response_type       pending[$];
      int                 errors;

      function new();
         depth = 0; pc = 0; resumable = 0; prog_len = 0; max_steps = 65535; errors = 0;
         foreach (var_ok[i]) var_ok[i] = 0;
         foreach (prog_op[i]) begin
            prog_op[i] = OP_ADDL;
            prog_arg[i] = '0;
         end
      endfunction

      function void set_register(logic [0:0] index, logic [15:0] data);
         if (index == REG_PROGRAM_LENGTH) prog_len = data[7:0];
         else max_steps = data;
      endfunction

      function logic [VALUE_W-1:0] saturate(longint v);
         if (v > 64'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
         if (v < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
         return v[VALUE_W-1:0];
      endfunction

      function longint widen(logic [VALUE_W-1:0] v);
         return longint'(signed'(v));
      endfunction

      // Runs the program from the current counter until something stops it.
      function response_type execute();
         response_type r;
         int           len;
         int           steps;
         logic [3:0]   op;
         logic [VALUE_W-1:0] arg;
         longint       a, b;
         bit           take;
         len = prog_len > 128 ? 128 : prog_len;
         steps = 0;
         r = '{status: ST_PRINT, value: '0, name: '0};
         forever begin
            if (pc >= len) begin
               resumable = 0; r.status = ST_END; return r;
            end
            if (steps >= max_steps) begin
               resumable = 1; r.status = ST_STEPS; return r;
            end
            steps++;
            op = prog_op[pc];
            arg = prog_arg[pc];
            case (op)
               OP_ADDL, OP_SUBL, OP_JMPEQ, OP_JMPGT, OP_JMPLT: begin
                  if (depth < 2) begin
                     resumable = 0; r.status = ST_UNDERFLOW; return r;
                  end
                  a = widen(stack_mem[depth-1]);
                  b = widen(stack_mem[depth-2]);
                  depth -= 2;
                  if (op == OP_ADDL || op == OP_SUBL) begin
                     stack_mem[depth] = saturate(op == OP_ADDL ? b + a : b - a);
                     depth++;
                     pc++;
                  end else begin
                     take = (op == OP_JMPEQ) ? (a == b) : (op == OP_JMPGT) ? (b > a) : (b < a);
                     pc = take ? int'(arg[6:0]) : pc + 1;
                  end
               end
               OP_ADDR, OP_SUBR, OP_ASSIGN: begin
                  if (depth < 1) begin
                     resumable = 0; r.status = ST_UNDERFLOW; return r;
                  end
                  a = widen(stack_mem[depth-1]);
                  if (op == OP_ASSIGN) begin
                     depth--;
                     vars[arg[7:0]] = stack_mem[depth];
                     var_ok[arg[7:0]] = 1;
                  end else begin
                     stack_mem[depth-1] =
                        saturate(op == OP_ADDR ? a + widen(arg) : a - widen(arg));
                  end
                  pc++;
               end
               OP_VAR, OP_CONST: begin
                  if ((op == OP_VAR && !var_ok[arg[7:0]]) || depth >= 16) begin
                     resumable = 0; r.status = ST_UNKNOWN; return r;
                  end
                  stack_mem[depth] = (op == OP_VAR) ? vars[arg[7:0]] : arg;
                  depth++;
                  pc++;
               end
               OP_JMP: pc = int'(arg[6:0]);
               OP_PRINT: begin
                  if (!var_ok[arg[7:0]]) begin
                     resumable = 0; r.status = ST_UNKNOWN; return r;
                  end
                  pc++;
                  resumable = 1;
                  r.status = ST_PRINT; r.value = vars[arg[7:0]]; r.name = arg[7:0];
                  return r;
               end
               default: begin
                  resumable = 0; r.status = ST_HALTED; return r;
               end
            endcase
         end
      endfunction

      // Notes an accepted request transaction and queues its response.
      function void note_request(logic [1:0] cmd, logic [6:0] addr, logic [3:0] opc,
                                 logic [VALUE_W-1:0] imm, logic [7:0] vname,
                                 logic [6:0] target);
         response_type r;
         logic [3:0]   op;
         r = '{status: ST_LOAD_ACK, value: '0, name: '0};
         if (cmd == CMD_LOAD) begin
            op = opc > OP_HALT ? OP_HALT : opc;
            prog_op[addr] = op;
            if (op == OP_ADDR || op == OP_SUBR || op == OP_CONST) prog_arg[addr] = imm;
            else if (op == OP_ASSIGN || op == OP_VAR || op == OP_PRINT)
               prog_arg[addr] = VALUE_W'(vname);
            else if (op >= OP_JMP && op <= OP_JMPLT) prog_arg[addr] = VALUE_W'(target);
            else prog_arg[addr] = '0;
         end else if (cmd == CMD_RUN) begin
            depth = 0; pc = 0;
            foreach (var_ok[i]) var_ok[i] = 0;
            r = execute();
         end else if (cmd == CMD_CONTINUE) begin
            if (resumable) r = execute();
            else r.status = ST_HALTED;
         end
         pending.push_back(r);
      endfunction

      // Compares one observed response with the oldest expectation.
      function void check_response(response_type got);
         response_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response status=%0d value=%h name=%h",
                     $time, got.status, got.value, got.name);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, got.value);
            errors++;
         end
         if (got.name !== want.name) begin
            $display("%0t: printed_name expected %h actual %h", $time, want.name, got.name);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [0:0]  csr_index = REG_PROGRAM_LENGTH;
   logic [15:0] csr_data = '0;

   smi_req_if req_ch();
   smi_rsp_if rsp_ch();

   interpreter_scoreboard board = new();

   int          stall_hold = 0;
   int          idle_cycles = 0;

   stack_machine_interpreter DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.cmd = CMD_LOAD;
      req_ch.load_address = '0;
      req_ch.opcode = OP_ADDL;
      req_ch.immediate = '0;
      req_ch.var_name = '0;
      req_ch.jump_target = '0;
      rsp_ch.ready = 0;
   end

   // Track accepted requests in the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_request(req_ch.cmd, req_ch.load_address, req_ch.opcode,
                            req_ch.immediate, req_ch.var_name, req_ch.jump_target);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_response('{status: rsp_ch.status, value: rsp_ch.value,
                                name: rsp_ch.printed_name});
   end

   // Receiver stalls on its own pattern, with a long hold-off on request.
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ch.ready <= 0;
      end else if (($time / 2000) % 3 == 0) begin
         rsp_ch.ready <= 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Watchdog on cycles without any transaction; a run may execute 65535
   // instructions before it answers.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Offers one request transaction and waits until it is accepted.
   task automatic send(logic [1:0] cmd, logic [6:0] addr, logic [3:0] opc,
                       logic [VALUE_W-1:0] imm, logic [7:0] vname, logic [6:0] target);
      req_ch.valid <= 1;
      req_ch.cmd <= cmd;
      req_ch.load_address <= addr;
      req_ch.opcode <= opc;
      req_ch.immediate <= imm;
      req_ch.var_name <= vname;
      req_ch.jump_target <= target;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Random gap between bursts; no valid change within a burst.
   task automatic pause(int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Waits at falling edges so that the scoreboard has seen the last acceptance.
   task automatic drain();
      req_ch.valid <= 0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] index, logic [15:0] data);
      csr_write <= 1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      board.set_register(index, data);
      csr_write <= 0;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0: return 48'h7FFF_FFFF_FFFF - $urandom_range(0, 3);
         1: return 48'h8000_0000_0000 + $urandom_range(0, 3);
         2: return {{32{1'b0}}, 16'($urandom_range(0, 3))} << 16;
         default: return {16'($urandom), $urandom};
      endcase
   endfunction

   // Loads a random program of given length; shapes are mostly well formed.
   task automatic load_program(int len, inout int burst);
      logic [3:0] opc;
      logic [7:0] vname;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0, 1: opc = OP_CONST;
            2: opc = OP_ASSIGN;
            3: opc = OP_PRINT;
            4: opc = OP_VAR;
            5: opc = $urandom_range(0, 1) ? OP_ADDL : OP_SUBL;
            6: opc = $urandom_range(0, 1) ? OP_ADDR : OP_SUBR;
            7: opc = 4'($urandom_range(OP_JMP, OP_JMPLT));
            8: opc = $urandom_range(0, 5) == 0 ? 4'($urandom_range(12, 15)) : OP_CONST;
            default: opc = 4'($urandom_range(0, 15));
         endcase
         vname = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(65, 68));
         send(CMD_LOAD, 7'(i), opc, random_value(), vname,
              7'($urandom_range(0, len + 1)));
         if (--burst <= 0) begin
            pause($urandom_range(0, 6));
            burst = $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      int burst;
      int len;
      int sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, every opcode and the named corner cases.
      write_register(REG_PROGRAM_LENGTH, 16'd0);
      write_register(REG_STEP_LIMIT, 16'd65535);
      send(CMD_RUN, 0, OP_ADDL, 0, 0, 0);          // empty program ends at once
      send(CMD_CONTINUE, 0, OP_ADDL, 0, 0, 0);     // nothing to continue
      send(2'd3, 7'h7F, 4'hF, '1, 8'hFF, 7'h7F);   // command three is ignored
      send(CMD_LOAD, 0, OP_CONST, 48'h7FFF_FFFF_FFFF, 8'hFF, 7'h7F);
      send(CMD_LOAD, 1, OP_ADDR, 48'h0000_0001_0000, 8'h00, 7'h00);
      send(CMD_LOAD, 2, OP_ASSIGN, '1, 8'hFF, 0);
      send(CMD_LOAD, 3, OP_PRINT, '1, 8'hFF, 0);
      send(CMD_LOAD, 4, OP_CONST, 48'h8000_0000_0000, 0, 0);
      send(CMD_LOAD, 5, OP_SUBR, 48'h0000_0000_0001, 0, 0);
      send(CMD_LOAD, 6, OP_VAR, 0, 8'hFF, 0);
      send(CMD_LOAD, 7, OP_SUBL, 0, 0, 0);
      send(CMD_LOAD, 8, OP_CONST, 0, 0, 0);
      send(CMD_LOAD, 9, OP_ADDL, 0, 0, 0);
      send(CMD_LOAD, 10, OP_JMPGT, 0, 0, 7'd12);
      send(CMD_LOAD, 11, OP_CONST, 5, 0, 0);
      send(CMD_LOAD, 12, OP_JMPEQ, 0, 0, 7'd3);
      send(CMD_LOAD, 13, OP_JMPLT, 0, 0, 7'd0);
      send(CMD_LOAD, 14, OP_JMP, 0, 0, 7'd16);
      send(CMD_LOAD, 15, 4'd13, 0, 0, 0);
      drain();
      write_register(REG_PROGRAM_LENGTH, 16'd16);
      send(CMD_RUN, 0, 0, 0, 0, 0);
      repeat (4) send(CMD_CONTINUE, 0, 0, 0, 0, 0);
      drain();
      write_register(REG_STEP_LIMIT, 16'd1);
      send(CMD_RUN, 0, 0, 0, 0, 0);
      send(CMD_CONTINUE, 0, 0, 0, 0, 0);
      drain();

      // Random programs under several register settings.
      sent = 0;
      burst = $urandom_range(1, 12);
      while (sent < 1600) begin
         len = $urandom_range(0, 9) == 0 ? $urandom_range(60, 128) : $urandom_range(2, 16);
         drain();
         load_program(len, burst);
         sent += len;
         drain();
         case ($urandom_range(0, 4))
            0: write_register(REG_PROGRAM_LENGTH, 16'($urandom_range(0, len)));
            1: write_register(REG_PROGRAM_LENGTH, 16'(len));
            default: write_register(REG_PROGRAM_LENGTH, 16'(len));
         endcase
         case ($urandom_range(0, 4))
            0: write_register(REG_STEP_LIMIT, 16'd1);
            1: write_register(REG_STEP_LIMIT, 16'd65535);
            2: write_register(REG_STEP_LIMIT, 16'($urandom_range(1, 65535)));
            default: write_register(REG_STEP_LIMIT, 16'($urandom_range(2, 60)));
         endcase
         if (sent > 800 && sent < 830) stall_hold = 300;   // long receiver hold-off
         for (int k = $urandom_range(2, 10); k > 0; k--) begin
            send($urandom_range(0, 3) == 0 ? CMD_RUN : CMD_CONTINUE, 0, 0, 0, 0, 0);
            sent++;
            if (--burst <= 0) begin
               pause($urandom_range(0, 6));
               burst = $urandom_range(1, 12);
            end
         end
         // Occasional load at the top address, then a random ignored command.
         if ($urandom_range(0, 3) == 0) begin
            send(CMD_LOAD, 7'h7F, 4'($urandom), {16'($urandom), $urandom}, 8'($urandom),
                 7'($urandom));
            send(2'd3, 7'($urandom), 4'($urandom), {16'($urandom), $urandom},
                 8'($urandom), 7'($urandom));
            sent += 2;
         end
      end
      // Make sure the long hold-off happened at least once.
      stall_hold = 300;
      repeat (6) send(CMD_RUN, 0, 0, 0, 0, 0);

      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/smi_pkg.sv
rtl/smi_channels.sv
rtl/smi_alu.sv
rtl/stack_machine_interpreter.sv
rtl/smi_checker.sv
tb/sv/testbench.sv
